### hdl/slt_pkg.sv
// shared types, token kind codes and character class helpers
// for the source line tokenizer; no dependencies
package slt_pkg;

  localparam int unsigned COL_W    = 12;
  localparam int unsigned KW_CHARS = 8;
  localparam int unsigned KW_NUM   = 9;
  localparam logic [COL_W-1:0] COL_CAP = 12'd4095;
  localparam logic [COL_W-1:0] LEN_CAP = 12'd4095;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [4:0] K_END     = 5'd0;
  localparam logic [4:0] K_IDENT   = 5'd1;
  localparam logic [4:0] K_INT     = 5'd2;
  localparam logic [4:0] K_FLOAT   = 5'd3;
  localparam logic [4:0] K_STRING  = 5'd4;
  localparam logic [4:0] K_KW0     = 5'd5;
  localparam logic [4:0] K_ANDAND  = 5'd14;
  localparam logic [4:0] K_OROR    = 5'd15;
  localparam logic [4:0] K_EQEQ    = 5'd16;
  localparam logic [4:0] K_BANGEQ  = 5'd17;
  localparam logic [4:0] K_LE      = 5'd18;
  localparam logic [4:0] K_GE      = 5'd19;
  localparam logic [4:0] K_LPAREN  = 5'd20;
  localparam logic [4:0] K_RPAREN  = 5'd21;
  localparam logic [4:0] K_LBRACE  = 5'd22;
  localparam logic [4:0] K_RBRACE  = 5'd23;
  localparam logic [4:0] K_BANG    = 5'd24;
  localparam logic [4:0] K_LESS    = 5'd25;
  localparam logic [4:0] K_GREATER = 5'd26;
  localparam logic [4:0] K_ASSIGN  = 5'd27;
  localparam logic [4:0] K_SEMI    = 5'd28;
  localparam logic [4:0] K_COMMA   = 5'd29;
  localparam logic [4:0] K_PLUS    = 5'd30;
  localparam logic [4:0] K_UNKNOWN = 5'd31;

  typedef enum logic [2:0] {
    M_IDLE, M_OP, M_IDENT, M_INT, M_INT_DOT, M_FLOAT, M_STRING
  } mode_t;

  typedef struct packed {
    logic [4:0]       kind;
    logic [COL_W-1:0] start;
    logic [COL_W-1:0] len;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [1:0]      n;
    res_t [2:0]      r;
  } res_batch_t;

  // keyword text, right aligned (first character in the highest used byte)
  localparam logic [63:0] KW_TEXT [KW_NUM] = '{
    64'("print"), 64'("read"), 64'("int"), 64'("str"), 64'("float"),
    64'("auto"), 64'("if"), 64'("else"), 64'("timeexec")
  };
  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd5, 4'd4, 4'd3, 4'd3, 4'd5, 4'd4, 4'd2, 4'd4, 4'd8
  };

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  // buffer holds character i in byte i
  function automatic logic [4:0] kw_kind(input logic [63:0] kbuf,
                                         input logic [COL_W-1:0] len);
    logic [4:0]  kind;
    logic [63:0] expect_buf;
    kind = K_IDENT;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      expect_buf = '0;
      for (int i = 0; i < KW_CHARS; i++) begin
        if (i < int'(KW_LEN[k]))
          expect_buf[8*i +: 8] = KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8];
      end
      if (len == COL_W'(KW_LEN[k]) && kbuf == expect_buf)
        kind = K_KW0 + 5'(k);
    end
    return kind;
  endfunction

endpackage

### hdl/source_line_tokenizer.sv
// top level of the source line tokenizer: scanner plus result queue
// depends on slt_pkg, slt_scan, slt_fifo
//
// takes one source byte per word (in_tuser low) or an end-of-line mark
// (in_tuser high) and returns tokens as kind, start column and length.
// whitespace and line comments are skipped, block comments carry over
// lines. one word is taken per cycle: the scanner decides each word
// combinationally and writes its zero to three tokens into a four-entry
// result queue. the input is ready while the queue holds at most one
// token, so a word is held back only when the output side drains slower
// than tokens are made (at most one token leaves per cycle). names, numbers
// and lone operators are reported once the next byte arrives, or at end
// of line, which always ends with an end-of-input token (kind 0, column =
// line length) carrying tlast; tlast marks the last token of every word
module source_line_tokenizer import slt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code
  input  logic        in_tuser,   // operation: 1 = end of line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // start_column [11:0], lexeme_length [23:12]
  output logic [4:0]  out_tuser,  // token_kind
  output logic        out_tlast   // last_of_run
);

  logic       take;
  res_batch_t batch;
  res_t       head;

  // word accepted
  assign take = in_tvalid && in_tready;

  slt_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .eol   (in_tuser),
    .ch    (in_tdata),
    .batch (batch)
  );

  slt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .batch     (batch),
    .pop_ready (out_tready),
    .pop_valid (out_tvalid),
    .pop_data  (head),
    .room      (in_tready)
  );

  assign out_tdata = {head.len, head.start};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

### hdl/slt_scan.sv
// scanner state and per-word token decision, up to three results per word
// depends on slt_pkg
module slt_scan import slt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic       eol,
  input  logic [7:0] ch,
  output res_batch_t batch
);

  logic             blk_r, blk_nxt, lcom_r, lcom_nxt;
  mode_t            mode_r, mode_nxt;
  logic [7:0]       pend_r, pend_nxt;
  logic [COL_W-1:0] col_r, col_nxt, tstart_r, tstart_nxt, ilen_r, ilen_nxt;
  logic [63:0]      kbuf_r, kbuf_nxt;

  // outcome of scanning ch from idle
  mode_t            b_mode;
  logic             b_pend, b_emit, b_ilen_w, b_kbuf_w;
  logic [4:0]       b_kind;
  logic [COL_W-1:0] b_tstart, b_ilen;

  logic [COL_W-1:0] col_inc, len_inc1, len_inc2, dot_col;
  logic [COL_W:0]   sum2, dsum;
  logic [4:0]       ident_kind, single_kind, pair_k;

  assign col_inc  = (col_r == COL_CAP) ? COL_CAP : col_r + 1'b1;
  assign len_inc1 = (ilen_r == LEN_CAP) ? LEN_CAP : ilen_r + 1'b1;
  assign sum2     = {1'b0, ilen_r} + (COL_W+1)'(2);
  assign len_inc2 = (sum2 > {1'b0, LEN_CAP}) ? LEN_CAP : sum2[COL_W-1:0];
  assign dsum     = {1'b0, tstart_r} + {1'b0, ilen_r};
  assign dot_col  = (dsum > {1'b0, COL_CAP}) ? COL_CAP : dsum[COL_W-1:0];
  assign ident_kind = kw_kind(kbuf_r, ilen_r);

  always_comb begin
    case (pend_r)
      "!":     single_kind = K_BANG;
      "<":     single_kind = K_LESS;
      ">":     single_kind = K_GREATER;
      "=":     single_kind = K_ASSIGN;
      default: single_kind = K_UNKNOWN;
    endcase
    pair_k = K_END;
    if (pend_r == "&" && ch == "&") pair_k = K_ANDAND;
    else if (pend_r == "|" && ch == "|") pair_k = K_OROR;
    else if (ch == "=") begin
      if (pend_r == "=") pair_k = K_EQEQ;
      else if (pend_r == "!") pair_k = K_BANGEQ;
      else if (pend_r == "<") pair_k = K_LE;
      else if (pend_r == ">") pair_k = K_GE;
    end
  end

  always_comb begin
    b_mode = M_IDLE; b_pend = 1'b0; b_emit = 1'b0; b_kind = K_UNKNOWN;
    b_tstart = col_r; b_ilen_w = 1'b0; b_ilen = '0; b_kbuf_w = 1'b0;
    if (!is_space(ch)) begin
      case (ch) inside
        "/", "&", "|", "=", "!", "<", ">": begin
          b_mode = M_OP; b_pend = 1'b1;
        end
        "(": begin b_emit = 1'b1; b_kind = K_LPAREN; end
        ")": begin b_emit = 1'b1; b_kind = K_RPAREN; end
        "{": begin b_emit = 1'b1; b_kind = K_LBRACE; end
        "}": begin b_emit = 1'b1; b_kind = K_RBRACE; end
        ";": begin b_emit = 1'b1; b_kind = K_SEMI; end
        ",": begin b_emit = 1'b1; b_kind = K_COMMA; end
        "+": begin b_emit = 1'b1; b_kind = K_PLUS; end
        "\"": begin
          b_mode = M_STRING; b_tstart = col_inc; b_ilen_w = 1'b1; b_ilen = '0;
        end
        default: begin
          if (is_digit(ch)) begin
            b_mode = M_INT; b_ilen_w = 1'b1; b_ilen = COL_W'(1);
          end else if (is_alpha(ch) || ch == "_") begin
            b_mode = M_IDENT; b_ilen_w = 1'b1; b_ilen = COL_W'(1); b_kbuf_w = 1'b1;
          end else begin
            b_emit = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    logic [1:0] n;
    logic       run_begin;
    n = '0;
    batch.r = '0;
    run_begin = 1'b0;
    blk_nxt = blk_r; lcom_nxt = lcom_r; mode_nxt = mode_r; pend_nxt = pend_r;
    col_nxt = col_r; tstart_nxt = tstart_r; ilen_nxt = ilen_r; kbuf_nxt = kbuf_r;
    if (eol) begin
      if (!lcom_r && !blk_r) begin
        case (mode_r)
          M_OP: begin
            batch.r[n] = '{single_kind, tstart_r, COL_W'(1), 1'b0}; n = n + 1'b1;
          end
          M_IDENT: begin
            batch.r[n] = '{ident_kind, tstart_r, ilen_r, 1'b0}; n = n + 1'b1;
          end
          M_INT: begin
            batch.r[n] = '{K_INT, tstart_r, ilen_r, 1'b0}; n = n + 1'b1;
          end
          M_INT_DOT: begin
            batch.r[n] = '{K_INT, tstart_r, ilen_r, 1'b0}; n = n + 1'b1;
            batch.r[n] = '{K_UNKNOWN, dot_col, COL_W'(1), 1'b0}; n = n + 1'b1;
          end
          M_FLOAT: begin
            batch.r[n] = '{K_FLOAT, tstart_r, ilen_r, 1'b0}; n = n + 1'b1;
          end
          M_STRING: begin
            batch.r[n] = '{K_STRING, tstart_r, ilen_r, 1'b0}; n = n + 1'b1;
          end
          default: ;
        endcase
      end
      batch.r[n] = '{K_END, col_r, '0, 1'b0}; n = n + 1'b1;
      lcom_nxt = 1'b0; mode_nxt = M_IDLE; pend_nxt = '0; col_nxt = '0; ilen_nxt = '0;
    end else begin
      col_nxt = col_inc;
      if (lcom_r) begin
        // rest of line is a comment
      end else if (blk_r) begin
        if (pend_r == "*" && ch == "/") begin
          blk_nxt = 1'b0; pend_nxt = '0;
        end else begin
          pend_nxt = (ch == "*") ? 8'("*") : 8'h00;
        end
      end else begin
        case (mode_r)
          M_OP: begin
            if (pend_r == "/" && ch == "/") begin
              lcom_nxt = 1'b1; mode_nxt = M_IDLE; pend_nxt = '0;
            end else if (pend_r == "/" && ch == "*") begin
              blk_nxt = 1'b1; mode_nxt = M_IDLE; pend_nxt = '0;
            end else if (pair_k != K_END) begin
              batch.r[n] = '{pair_k, tstart_r, COL_W'(2), 1'b0}; n = n + 1'b1;
              mode_nxt = M_IDLE; pend_nxt = '0;
            end else begin
              batch.r[n] = '{single_kind, tstart_r, COL_W'(1), 1'b0}; n = n + 1'b1;
              pend_nxt = '0;
              run_begin = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_word(ch)) begin
              if (ilen_r < COL_W'(KW_CHARS)) kbuf_nxt[8*ilen_r[2:0] +: 8] = ch;
              ilen_nxt = len_inc1;
            end else begin
              batch.r[n] = '{ident_kind, tstart_r, ilen_r, 1'b0}; n = n + 1'b1;
              run_begin = 1'b1;
            end
          end
          M_INT: begin
            if (is_digit(ch)) ilen_nxt = len_inc1;
            else if (ch == ".") mode_nxt = M_INT_DOT;
            else begin
              batch.r[n] = '{K_INT, tstart_r, ilen_r, 1'b0}; n = n + 1'b1;
              run_begin = 1'b1;
            end
          end
          M_INT_DOT: begin
            if (is_digit(ch)) begin
              mode_nxt = M_FLOAT; ilen_nxt = len_inc2;
            end else begin
              batch.r[n] = '{K_INT, tstart_r, ilen_r, 1'b0}; n = n + 1'b1;
              batch.r[n] = '{K_UNKNOWN, dot_col, COL_W'(1), 1'b0}; n = n + 1'b1;
              run_begin = 1'b1;
            end
          end
          M_FLOAT: begin
            if (is_digit(ch)) ilen_nxt = len_inc1;
            else begin
              batch.r[n] = '{K_FLOAT, tstart_r, ilen_r, 1'b0}; n = n + 1'b1;
              run_begin = 1'b1;
            end
          end
          M_STRING: begin
            if (ch == "\"") begin
              batch.r[n] = '{K_STRING, tstart_r, ilen_r, 1'b0}; n = n + 1'b1;
              mode_nxt = M_IDLE;
            end else begin
              ilen_nxt = len_inc1;
            end
          end
          default: run_begin = 1'b1;
        endcase
        if (run_begin) begin
          mode_nxt = b_mode;
          if (b_pend) begin
            pend_nxt = ch; tstart_nxt = b_tstart;
          end
          if (b_ilen_w) begin
            ilen_nxt = b_ilen; tstart_nxt = b_tstart;
          end
          if (b_kbuf_w) kbuf_nxt = {56'h0, ch};
          if (b_emit && n != 2'd3) begin
            batch.r[n] = '{b_kind, col_r, COL_W'(1), 1'b0}; n = n + 1'b1;
          end
        end
      end
    end
    if (n != 2'd0) batch.r[n - 1'b1].last = 1'b1;
    batch.n = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r <= 1'b0; lcom_r <= 1'b0; mode_r <= M_IDLE; pend_r <= '0;
      col_r <= '0; tstart_r <= '0; ilen_r <= '0; kbuf_r <= '0;
    end else if (take) begin
      blk_r <= blk_nxt; lcom_r <= lcom_nxt; mode_r <= mode_nxt; pend_r <= pend_nxt;
      col_r <= col_nxt; tstart_r <= tstart_nxt; ilen_r <= ilen_nxt; kbuf_r <= kbuf_nxt;
    end
  end

endmodule

### hdl/slt_fifo.sv
// result queue: takes up to three results per cycle, hands out one
// depends on slt_pkg
module slt_fifo import slt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  res_batch_t batch,
  input  logic       pop_ready,
  output logic       pop_valid,
  output res_t       pop_data,
  output logic       room
);

  localparam int unsigned PW = $clog2(FIFO_DEPTH);

  res_t          mem [FIFO_DEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [PW:0]   count_r;
  logic          pop;
  logic [1:0]    n_in;

  assign pop_valid = count_r != '0;
  assign pop_data  = mem[rptr_r];
  assign pop       = pop_valid && pop_ready;
  assign room      = count_r < (PW+1)'(2);
  assign n_in      = push ? batch.n : 2'd0;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n_in) mem[wptr_r + PW'(i)] <= batch.r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0; rptr_r <= '0; count_r <= '0;
    end else begin
      wptr_r  <= wptr_r + PW'(n_in);
      rptr_r  <= rptr_r + PW'(pop);
      count_r <= count_r + (PW+1)'(n_in) - (PW+1)'(pop);
    end
  end

endmodule

### hdl/slt_checker.sv
// port-level checks for the source line tokenizer, bound to the top level
// depends on slt_pkg and the source_line_tokenizer ports
module slt_checker import slt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [4:0]  out_tuser,
  input logic        out_tlast
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  // queue empty after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("not empty after reset");

  // end-of-input has zero length
  a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == K_END |-> out_tdata[23:12] == 12'd0)
    else $error("end token with nonzero length");

  // end-of-input always closes its run
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == K_END |-> out_tlast)
    else $error("end token without tlast");

endmodule

bind source_line_tokenizer slt_checker u_slt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
